// ===== src/hfc_pkg.sv =====
package hfc_pkg;

  localparam int unsigned LaneCount = 4;
  localparam int unsigned WordWidth = 32;

  typedef logic [WordWidth-1:0] word_t;

  typedef enum logic {
    OpSingleToHalf = 1'b0,
    OpHalfToSingle = 1'b1
  } op_e;

  // single precision fields
  localparam logic [7:0]  SglExpMax    = 8'hFF;
  // half biased exponent = single biased exponent - 112
  localparam logic [7:0]  SglToHalfLow = 8'd112;
  localparam logic [7:0]  SglToHalfOvf = 8'd143;
  localparam logic [7:0]  HalfToSglAdd = 8'd112;
  // subnormal half: single exponent = leading one position + 103
  localparam logic [7:0]  SubnormBase  = 8'd103;
  localparam logic [4:0]  HalfExpMax   = 5'h1F;
  localparam logic [15:0] HalfInf      = 16'h7C00;

endpackage

// ===== src/hfc_lane.sv =====
module hfc_lane (
  input  hfc_pkg::op_e  op_i,
  input  hfc_pkg::word_t data_i,
  output hfc_pkg::word_t data_o
);
  import hfc_pkg::*;

  // single to half
  logic        s_sgn;
  logic [7:0]  s_exp;
  logic [7:0]  s_exp_rb;
  logic [15:0] half_res;

  // half to single
  logic        h_sgn;
  logic [4:0]  h_exp;
  logic [9:0]  h_frac;
  logic [3:0]  lead_pos;
  logic [3:0]  lead_zeros;
  logic [9:0]  norm_frac;
  logic [7:0]  sub_exp;
  logic [7:0]  nrm_exp;
  word_t       sgl_res;

  assign s_sgn    = data_i[31];
  assign s_exp    = data_i[30:23];
  assign s_exp_rb = s_exp - SglToHalfLow;

  always_comb begin
    if (s_exp <= SglToHalfLow) begin
      half_res = {s_sgn, 15'd0};
    end else if (s_exp >= SglToHalfOvf) begin
      half_res = {s_sgn, HalfInf[14:0]};
    end else begin
      half_res = {s_sgn, s_exp_rb[4:0], data_i[22:13]};
    end
  end

  assign h_sgn  = data_i[15];
  assign h_exp  = data_i[14:10];
  assign h_frac = data_i[9:0];

  // priority encoder for the leading one of a subnormal mantissa
  always_comb begin
    lead_pos = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (h_frac[i]) begin
        lead_pos = 4'(i);
      end
    end
  end

  assign lead_zeros = 4'd9 - lead_pos;
  assign norm_frac  = h_frac << lead_zeros;
  assign sub_exp    = SubnormBase + {4'd0, lead_pos};
  assign nrm_exp    = {3'd0, h_exp} + HalfToSglAdd;

  always_comb begin
    if (h_exp == 5'd0) begin
      if (h_frac == 10'd0) begin
        sgl_res = {h_sgn, 31'd0};
      end else begin
        // leading one drops out as the hidden bit
        sgl_res = {h_sgn, sub_exp, norm_frac[8:0], 14'd0};
      end
    end else if (h_exp == HalfExpMax) begin
      sgl_res = {h_sgn, SglExpMax, h_frac, 13'd0};
    end else begin
      sgl_res = {h_sgn, nrm_exp, h_frac, 13'd0};
    end
  end

  always_comb begin
    case (op_i)
      OpSingleToHalf: data_o = {16'd0, half_res};
      OpHalfToSingle: data_o = sgl_res;
      default:        data_o = {16'd0, half_res};
    endcase
  end

endmodule

// ===== src/half_float_converter_x4.sv =====
// Four-lane converter between single and half precision bit patterns. Each
// transaction carries an operation bit and four lane words; all lanes convert
// in parallel and the results land in an output register, so a
// result appears in the cycle after its transaction is accepted and the block
// takes one transaction per cycle as long as the output side keeps up. The
// output register is the only stage: when it holds a result that is not
// taken, input ready drops until it is. Single to half truncates, flushes
// small values to signed zero and large values, infinity and NaN to signed
// infinity; half to single is exact, with subnormals normalized.
module half_float_converter_x4 (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  operation_i,
  input  logic [31:0] lane_a_in_i,
  input  logic [31:0] lane_b_in_i,
  input  logic [31:0] lane_c_in_i,
  input  logic [31:0] lane_d_in_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output logic [31:0] lane_a_out_o,
  output logic [31:0] lane_b_out_o,
  output logic [31:0] lane_c_out_o,
  output logic [31:0] lane_d_out_o
);
  import hfc_pkg::*;

  op_e   op;
  word_t lane_in  [LaneCount];
  word_t lane_res [LaneCount];
  word_t res_q    [LaneCount];
  logic  valid_q;
  logic  valid_d;
  logic  in_fire;

  assign op         = op_e'(operation_i);
  assign lane_in[0] = lane_a_in_i;
  assign lane_in[1] = lane_b_in_i;
  assign lane_in[2] = lane_c_in_i;
  assign lane_in[3] = lane_d_in_i;

  for (genvar g = 0; g < LaneCount; g++) begin : g_lane
    hfc_lane u_lane (
      .op_i   (op),
      .data_i (lane_in[g]),
      .data_o (lane_res[g])
    );
  end

  assign in_ready_o = !valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (in_fire) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // merge the lane results into the output register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int i = 0; i < LaneCount; i++) begin
        res_q[i] <= lane_res[i];
      end
    end
  end

  assign out_valid_o  = valid_q;
  assign lane_a_out_o = res_q[0];
  assign lane_b_out_o = res_q[1];
  assign lane_c_out_o = res_q[2];
  assign lane_d_out_o = res_q[3];

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted transaction did not produce a result");

  a_half_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !operation_i) |=>
      (lane_a_out_o[31:16] == 16'd0 && lane_b_out_o[31:16] == 16'd0 &&
       lane_c_out_o[31:16] == 16'd0 && lane_d_out_o[31:16] == 16'd0))
    else $error("half result has nonzero upper bits");

  a_zero_stays_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && operation_i && lane_a_in_i[14:0] == 15'd0) |=>
      (lane_a_out_o[30:0] == 31'd0 && lane_a_out_o[31] == $past(lane_a_in_i[15])))
    else $error("half zero did not convert to single zero");

endmodule
